>>> hw/rtl/sre_pkg.sv
// types and codes shared by the sed replacement expander
// holds the input and result beat structs, action and result codes
// no dependencies
package sre_pkg;

  // input action codes
  localparam logic [1:0] ActTemplate = 2'd0;
  localparam logic [1:0] ActGroup    = 2'd1;
  localparam logic [1:0] ActEnd      = 2'd2;

  // result kinds
  localparam logic [1:0] KindChar    = 2'd0;
  localparam logic [1:0] KindRequest = 2'd1;
  localparam logic [1:0] KindDone    = 2'd2;

  // configuration register indexes
  localparam logic RegGroupCount = 1'b0;

  localparam logic [3:0] GroupCountReset = 4'd10;

  // result queue
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // template characters
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChAmp       = 8'h26;
  localparam logic [7:0] ChN         = 8'h6e;
  localparam logic [7:0] ChLowL      = 8'h6c;
  localparam logic [7:0] ChLowU      = 8'h75;
  localparam logic [7:0] ChUpL       = 8'h4c;
  localparam logic [7:0] ChUpU       = 8'h55;
  localparam logic [7:0] ChUpE       = 8'h45;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChOne       = 8'h31;
  localparam logic [7:0] ChNine      = 8'h39;
  localparam logic [7:0] ChNewline   = 8'h0a;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_char;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] out_char;
    logic [3:0] group_index;
  } out_item_t;

endpackage

>>> hw/rtl/sed_replacement_expander_unit.sv
// sed replacement expander: template decode, case filter and result queue
// depends on sre_pkg
//
// usage: template bytes (action 0), group text bytes (action 1) and an end
// marker (action 2) arrive as beats on the in channel. each beat yields up to
// two result beats on the out channel: a case-filtered character, a group
// request, or expansion done. after a request the supplier streams that
// group's bytes back as action 1 beats; a group that did not match sends none.
// group_count is written through the apb port at address 0, by the user only
// while idle; the block itself does not enforce this. timing: a beat is
// captured in an input register, decoded combinationally from it and written
// into a four-entry result queue when the queue has room; its first result
// can then be taken from the queue head. one input beat per cycle is sustained
// while the queue has room; the end marker with a trailing backslash makes
// two result beats; the output drains at one beat per cycle when not stalled.
// the input register holds (in_stall_o high) while the queue has fewer than
// two free entries, so an out_stall_i backs up into the in channel after the
// queue fills. reset clears the case and escape flags, empties the queue and
// sets group_count to 10.
module sed_replacement_expander_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sre_pkg::in_item_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sre_pkg::out_item_t out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import sre_pkg::*;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    to_lower = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    to_upper = (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
  endfunction

  // configuration
  logic [3:0] group_count_q;
  logic       cfg_wr;
  logic       reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == RegGroupCount);
  assign cfg_wr  = psel && penable && pwrite && reg_hit;
  assign prdata  = reg_hit ? {28'd0, group_count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_count_q <= GroupCountReset;
    end else if (cfg_wr) begin
      group_count_q <= pwdata[3:0];
    end
  end

  // input register
  logic     s_valid_q;
  in_item_t s_item_q;
  logic     room;
  logic     s_fire;
  logic     in_fire;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign room       = cnt_q <= QCntW'(QDepth - 2);
  assign s_fire     = s_valid_q && room;
  assign in_stall_o = s_valid_q && !room;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_fire) begin
      s_valid_q <= 1'b1;
    end else if (s_fire) begin
      s_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s_item_q <= in_data_i;
    end
  end

  // decode and case filter
  logic esc_q, esc_d;
  logic lnext_q, lnext_d, unext_q, unext_d;
  logic lon_q, lon_d, uon_q, uon_d;
  logic       emit, req, done;
  logic [7:0] src, filt;
  logic [3:0] req_grp;
  logic [3:0] digit;
  logic [7:0] c;
  out_item_t  r0, r1;
  logic [1:0] push_n;

  assign c     = s_item_q.data_char;
  assign digit = 4'(c - ChZero);

  always_comb begin
    esc_d   = esc_q;
    lnext_d = lnext_q;
    unext_d = unext_q;
    lon_d   = lon_q;
    uon_d   = uon_q;
    emit    = 1'b0;
    req     = 1'b0;
    done    = 1'b0;
    src     = c;
    req_grp = 4'd0;
    if (s_fire) begin
      case (s_item_q.action)
        ActGroup: begin
          emit = 1'b1;
        end
        ActEnd: begin
          emit = esc_q;
          src  = ChBackslash;
          done = 1'b1;
        end
        ActTemplate: begin
          if (!esc_q) begin
            if (c == ChBackslash) begin
              esc_d = 1'b1;
            end else if (c == ChAmp) begin
              req = 1'b1;
            end else begin
              emit = 1'b1;
            end
          end else begin
            esc_d = 1'b0;
            if (c >= ChOne && c <= ChNine) begin
              req     = digit < group_count_q;
              req_grp = digit;
            end else begin
              case (c)
                ChN: begin
                  emit = 1'b1;
                  src  = ChNewline;
                end
                ChLowL: begin
                  lnext_d = 1'b1;
                  unext_d = 1'b0;
                end
                ChLowU: begin
                  unext_d = 1'b1;
                  lnext_d = 1'b0;
                end
                ChUpL: begin
                  lon_d = 1'b1;
                  uon_d = 1'b0;
                end
                ChUpU: begin
                  uon_d = 1'b1;
                  lon_d = 1'b0;
                end
                ChUpE: begin
                  lon_d   = 1'b0;
                  uon_d   = 1'b0;
                  lnext_d = 1'b0;
                  unext_d = 1'b0;
                end
                default: begin
                  emit = 1'b1;
                end
              endcase
            end
          end
        end
        default: ;
      endcase
    end

    // one-shot flags are consumed by the emitted character
    if (lnext_q)      filt = to_lower(src);
    else if (unext_q) filt = to_upper(src);
    else if (lon_q)   filt = to_lower(src);
    else if (uon_q)   filt = to_upper(src);
    else              filt = src;
    if (emit) begin
      if (lnext_q) lnext_d = 1'b0;
      else         unext_d = 1'b0;
    end

    if (done) begin
      esc_d   = 1'b0;
      lnext_d = 1'b0;
      unext_d = 1'b0;
      lon_d   = 1'b0;
      uon_d   = 1'b0;
    end

    r1 = '{result_kind: KindDone, out_char: 8'd0, group_index: 4'd0};
    if (emit) begin
      r0 = '{result_kind: KindChar, out_char: filt, group_index: 4'd0};
    end else if (req) begin
      r0 = '{result_kind: KindRequest, out_char: 8'd0, group_index: req_grp};
    end else begin
      r0 = r1;
    end
    push_n = {1'b0, emit || req || done} + {1'b0, emit && done};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q   <= 1'b0;
      lnext_q <= 1'b0;
      unext_q <= 1'b0;
      lon_q   <= 1'b0;
      uon_q   <= 1'b0;
    end else begin
      esc_q   <= esc_d;
      lnext_q <= lnext_d;
      unext_q <= unext_d;
      lon_q   <= lon_d;
      uon_q   <= uon_d;
    end
  end

  // result queue
  out_item_t        q_mem [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW-1:0] wr_nxt;
  logic             pop;

  assign wr_nxt      = wr_q + QPtrW'(1);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = q_mem[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign cnt_d       = cnt_q + QCntW'(push_n) - QCntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      q_mem[wr_q] <= r0;
    end
    if (push_n == 2'd2) begin
      q_mem[wr_nxt] <= r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPtrW'(push_n);
      rd_q  <= rd_q + QPtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("result queue count overflow");

  a_two_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_n == 2'd2 |-> s_item_q.action == ActEnd)
    else $error("two results from a non-end beat");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_item_q.action == ActEnd) |=>
      !esc_q && !lnext_q && !unext_q && !lon_q && !uon_q)
    else $error("state not cleared after end of template");

  a_req_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n != 2'd0 && r0.result_kind == KindRequest) |->
      (r0.group_index == 4'd0 || r0.group_index < group_count_q))
    else $error("group request out of range");

  a_no_push_without_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_n != 2'd0 |-> s_valid_q && cnt_q <= QCntW'(QDepth - 2))
    else $error("push into a full result queue");

endmodule

>>> dv/sed_replacement_expander_unit_tb.sv
// testbench for sed_replacement_expander_unit: template, group text and end beats
// are sent in and every result beat is checked against an in-bench expander
// depends on sre_pkg and the unit rtl
module sed_replacement_expander_unit_tb;
  import sre_pkg::*;

  localparam logic [1:0] ActUnused = 2'd3;
  localparam logic [2:0] AddrGroupCount = {RegGroupCount, 2'b00};
  localparam int unsigned PredDepth = 64;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // expander state as the bench sees it
  logic [3:0]  slot_count;
  logic        esc_open;
  logic        low_once;
  logic        up_once;
  logic        low_all;
  logic        up_all;
  // ring of predicted result beats not yet seen at the output
  out_item_t   pred_mem [PredDepth];
  logic [5:0]  pred_wr;
  logic [5:0]  pred_rd;

  int unsigned beats_sent;
  int unsigned fail_count;
  int unsigned send_idle_pct;
  int unsigned out_stall_pct;

  sed_replacement_expander_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
  endfunction

  // one-shot flags win over the sticky modes and are consumed
  function automatic logic [7:0] apply_case(input logic [7:0] c);
    if (low_once) begin
      low_once = 1'b0;
      return to_lower(c);
    end
    if (up_once) begin
      up_once = 1'b0;
      return to_upper(c);
    end
    if (low_all) return to_lower(c);
    if (up_all) return to_upper(c);
    return c;
  endfunction

  function automatic void push_result(input logic [1:0] kind, input logic [7:0] ch,
                                      input logic [3:0] grp);
    out_item_t r;
    r.result_kind = kind;
    r.out_char    = ch;
    r.group_index = grp;
    pred_mem[pred_wr] = r;
    pred_wr = pred_wr + 6'd1;
  endfunction

  function automatic void push_char(input logic [7:0] c);
    push_result(KindChar, apply_case(c), 4'd0);
  endfunction

  function automatic void expand_beat(input in_item_t b);
    logic [7:0] digit;
    case (b.action)
      ActGroup: push_char(b.data_char);
      ActEnd: begin
        if (esc_open) push_char(ChBackslash);
        push_result(KindDone, 8'd0, 4'd0);
        esc_open = 1'b0;
        low_once = 1'b0;
        up_once  = 1'b0;
        low_all  = 1'b0;
        up_all   = 1'b0;
      end
      ActTemplate: begin
        if (!esc_open) begin
          if (b.data_char == ChBackslash) esc_open = 1'b1;
          else if (b.data_char == ChAmp) push_result(KindRequest, 8'd0, 4'd0);
          else push_char(b.data_char);
        end else begin
          esc_open = 1'b0;
          if (b.data_char >= ChOne && b.data_char <= ChNine) begin
            digit = b.data_char - ChZero;
            if (digit[3:0] < slot_count) push_result(KindRequest, 8'd0, digit[3:0]);
          end else begin
            case (b.data_char)
              ChN: push_char(ChNewline);
              ChLowL: begin
                low_once = 1'b1;
                up_once  = 1'b0;
              end
              ChLowU: begin
                up_once  = 1'b1;
                low_once = 1'b0;
              end
              ChUpL: begin
                low_all = 1'b1;
                up_all  = 1'b0;
              end
              ChUpU: begin
                up_all  = 1'b1;
                low_all = 1'b0;
              end
              ChUpE: begin
                low_all  = 1'b0;
                up_all   = 1'b0;
                low_once = 1'b0;
                up_once  = 1'b0;
              end
              default: push_char(b.data_char);
            endcase
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pred_wr == pred_rd) begin
        $display("%0t: unexpected result beat, expected none actual %h", $time, out_data_o);
        fail_count++;
      end else begin
        want = pred_mem[pred_rd];
        pred_rd = pred_rd + 6'd1;
        check_field("result_kind", 8'(want.result_kind), 8'(out_data_o.result_kind));
        check_field("out_char", want.out_char, out_data_o.out_char);
        check_field("group_index", 8'(want.group_index), 8'(out_data_o.group_index));
      end
    end
  end

  always @(posedge clk_i) out_stall_i <= ($urandom_range(0, 99) < out_stall_pct);

  task automatic send_beat(input logic [1:0] act, input logic [7:0] ch);
    in_item_t b;
    b.action    = act;
    b.data_char = ch;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    expand_beat(b);
    beats_sent++;
  endtask

  task automatic send_escape(input logic [7:0] ch);
    send_beat(ActTemplate, ChBackslash);
    send_beat(ActTemplate, ch);
  endtask

  // let the output drain, then give silent beats time to leave the pipe
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pred_wr != pred_rd) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_group_count(input logic [3:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrGroupCount;
    pwdata  <= {28'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    slot_count = v;
  endtask

  // mostly letters so the case filter has work to do
  function automatic logic [7:0] rand_text();
    int unsigned pick;
    pick = $urandom_range(0, 3);
    if (pick == 0) return 8'($urandom_range(8'h41, 8'h5a));
    if (pick == 1) return 8'($urandom_range(8'h61, 8'h7a));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_group_text();
    repeat ($urandom_range(0, 4)) send_beat(ActGroup, rand_text());
  endtask

  task automatic send_random_template();
    logic [7:0] esc_set[8];
    int unsigned pick;
    esc_set = '{ChN, ChLowL, ChLowU, ChUpL, ChUpU, ChUpE, ChAmp, ChBackslash};
    repeat ($urandom_range(1, 10)) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        send_beat(ActTemplate, rand_text());
      end else if (pick == 4) begin
        send_beat(ActTemplate, ChAmp);
        send_group_text();
      end else if (pick < 7) begin
        send_escape(ChZero + 8'($urandom_range(0, 9)));
        send_group_text();
      end else if (pick < 9) begin
        if ($urandom_range(0, 3) == 0) send_escape(8'($urandom_range(0, 255)));
        else send_escape(esc_set[$urandom_range(0, 7)]);
      end else begin
        send_group_text();
      end
    end
    if ($urandom_range(0, 9) == 0) send_beat(ActTemplate, ChBackslash);
    send_beat(ActEnd, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_directed_escapes();
    send_beat(ActTemplate, 8'h00);
    send_beat(ActTemplate, 8'hff);
    send_beat(ActTemplate, ChAmp);
    send_escape(ChOne);
    send_escape(ChNine);
    send_escape(ChZero);
    send_escape(ChN);
    send_escape(ChAmp);
    send_escape(ChLowU);
    send_beat(ActGroup, "x");
    send_escape(ChUpU);
    send_escape(ChLowL);
    send_beat(ActGroup, "W");
    send_beat(ActTemplate, "v");
    send_escape(ChUpL);
    send_beat(ActTemplate, "Q");
    // group text arriving while an escape is open leaves it open
    send_beat(ActTemplate, ChBackslash);
    send_beat(ActGroup, "B");
    send_beat(ActTemplate, ChUpE);
    send_beat(ActUnused, 8'hff);
    // trailing backslash comes out at the end marker
    send_beat(ActTemplate, ChBackslash);
    send_beat(ActEnd, 8'h00);
    settle();
  endtask

  task automatic test_group_limit();
    write_group_count(4'd1);
    send_escape(ChOne);
    send_escape(ChNine);
    send_beat(ActTemplate, ChAmp);
    send_beat(ActEnd, 8'hff);
    settle();
  endtask

  task automatic test_random_phase(input int unsigned tx_idle, input int unsigned rx_idle,
                                   input logic [3:0] slots, input int unsigned upto);
    send_idle_pct = tx_idle;
    out_stall_pct = rx_idle;
    write_group_count(slots);
    while (beats_sent < upto) begin
      if ($urandom_range(0, 6) == 0)
        repeat ($urandom_range(1, 5))
          send_beat(2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)));
      else
        send_random_template();
    end
    settle();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    slot_count  = GroupCountReset;
    esc_open    = 1'b0;
    low_once    = 1'b0;
    up_once     = 1'b0;
    low_all     = 1'b0;
    up_all      = 1'b0;
    pred_wr     = '0;
    pred_rd     = '0;
    beats_sent  = 0;
    fail_count  = 0;
    send_idle_pct = 22;
    out_stall_pct = 88;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_escapes();
    test_group_limit();
    test_random_phase(22, 88, 4'($urandom_range(2, 9)), 500);
    test_random_phase(88, 22, 4'd10, 990);
    test_random_phase(0, 0, 4'd1, 1480);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
